FILE: sv/sctc_pkg.sv
// Shared types, constants and register codes for the smart-card character transceiver.
package sctc_pkg;

    localparam int ETU_W     = 16;
    localparam int GUARD_W   = 4;
    localparam int BIDX_W    = 4;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = ETU_W;

    localparam logic [ETU_W-1:0]   ETU_RESET   = ETU_W'(372);
    localparam logic [ETU_W-1:0]   ETU_MIN     = ETU_W'(2);
    localparam logic [GUARD_W-1:0] GUARD_RESET = GUARD_W'(2);

    // character step positions
    localparam logic [BIDX_W-1:0] BIDX_FIRST  = BIDX_W'(1);
    localparam logic [BIDX_W-1:0] BIDX_LAST_D = BIDX_W'(8);
    localparam logic [BIDX_W-1:0] BIDX_PAR    = BIDX_W'(9);

    localparam logic [BYTE_W-1:0] BYTE_ERR = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_ETU   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GUARD = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RX    = 2'd1,
        PH_TX    = 2'd2,
        PH_GUARD = 2'd3
    } phase_t;

    typedef struct packed {
        logic [ETU_W-1:0]   etu_ticks;
        logic [GUARD_W-1:0] guard_etus;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [ETU_W-1:0]   tick_count;
        logic [BIDX_W-1:0]  bit_index;
        logic [BYTE_W-1:0]  shift_bits;
        logic               parity_acc;
        logic               line_out;
    } link_state_t;

    typedef struct packed {
        logic              io_drive;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              parity_error;
        logic              tx_done;
        logic              busy_res;
        logic              request_dropped;
    } result_t;

endpackage

FILE: sv/sctc_cfg.sv
// Configuration registers: ETU length and guard time.
module sctc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sctc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sctc_pkg::CFG_W-1:0]     cfg_wdata,
    output sctc_pkg::cfg_t                 cfg
);
    import sctc_pkg::*;

    logic [ETU_W-1:0]   etu_reg;
    logic [ETU_W-1:0]   etu_next;
    logic [GUARD_W-1:0] guard_reg;
    logic [GUARD_W-1:0] guard_next;

    always_comb
    begin
        etu_next   = etu_reg;
        guard_next = guard_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ETU:   etu_next   = cfg_wdata[ETU_W-1:0];
                REG_GUARD: guard_next = cfg_wdata[GUARD_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            etu_reg   <= ETU_RESET;
            guard_reg <= GUARD_RESET;
        end
        else
        begin
            etu_reg   <= etu_next;
            guard_reg <= guard_next;
        end
    end

    assign cfg.etu_ticks  = etu_reg;
    assign cfg.guard_etus = guard_reg;

endmodule

FILE: sv/sctc_step.sv
// One tick of the character link: next link state and the result of the tick.
module sctc_step (
    input  sctc_pkg::cfg_t                  cfg,
    input  sctc_pkg::link_state_t           st,
    input  logic                            kind,
    input  logic                            io_level,
    input  logic [sctc_pkg::BYTE_W-1:0]     tx_byte,
    output sctc_pkg::link_state_t           st_next,
    output sctc_pkg::result_t               res
);
    import sctc_pkg::*;

    logic [ETU_W-1:0] eff_etu;
    logic [ETU_W-1:0] tick_dec;
    logic             expire;

    assign eff_etu  = (cfg.etu_ticks < ETU_MIN) ? ETU_MIN : cfg.etu_ticks;
    assign tick_dec = st.tick_count - ETU_W'(1);
    assign expire   = (tick_dec == '0);

    // next state
    always_comb
    begin
        st_next = st;
        if (st.phase == PH_IDLE)
        begin
            priority if (kind)
            begin
                st_next.phase      = PH_TX;
                st_next.line_out   = 1'b0;
                st_next.shift_bits = tx_byte;
                st_next.parity_acc = 1'b0;
                st_next.bit_index  = '0;
                st_next.tick_count = eff_etu;
            end
            else if (!io_level)
            begin
                st_next.phase      = PH_RX;
                st_next.shift_bits = '0;
                st_next.parity_acc = 1'b0;
                st_next.bit_index  = '0;
                st_next.tick_count = eff_etu;
            end
            else
            begin
                // line high and no request: stay idle
            end
        end
        else
        begin
            st_next.tick_count = tick_dec;
            if (expire)
            begin
                unique case (st.phase)
                    PH_RX:
                    begin
                        priority if (st.bit_index == '0)
                        begin
                            // start edge to middle of first data bit: 1.5 ETU
                            st_next.tick_count = eff_etu >> 1;
                            st_next.bit_index  = BIDX_FIRST;
                        end
                        else if (st.bit_index <= BIDX_LAST_D)
                        begin
                            st_next.shift_bits = {io_level, st.shift_bits[BYTE_W-1:1]};
                            st_next.parity_acc = st.parity_acc ^ io_level;
                            st_next.tick_count = eff_etu;
                            st_next.bit_index  = st.bit_index + BIDX_W'(1);
                        end
                        else if (st.bit_index == BIDX_PAR)
                        begin
                            st_next.parity_acc = st.parity_acc ^ io_level;
                            st_next.tick_count = eff_etu;
                            st_next.bit_index  = st.bit_index + BIDX_W'(1);
                        end
                        else
                        begin
                            st_next.phase     = PH_IDLE;
                            st_next.bit_index = '0;
                        end
                    end
                    PH_TX:
                    begin
                        priority if (st.bit_index < BIDX_LAST_D)
                        begin
                            st_next.line_out   = st.shift_bits[0];
                            st_next.parity_acc = st.parity_acc ^ st.shift_bits[0];
                            st_next.shift_bits = st.shift_bits >> 1;
                            st_next.tick_count = eff_etu;
                            st_next.bit_index  = st.bit_index + BIDX_W'(1);
                        end
                        else if (st.bit_index == BIDX_LAST_D)
                        begin
                            st_next.line_out   = st.parity_acc;
                            st_next.tick_count = eff_etu;
                            st_next.bit_index  = BIDX_PAR;
                        end
                        else
                        begin
                            st_next.line_out = 1'b1;
                            if (cfg.guard_etus == '0)
                            begin
                                st_next.phase     = PH_IDLE;
                                st_next.bit_index = '0;
                            end
                            else
                            begin
                                st_next.phase      = PH_GUARD;
                                st_next.bit_index  = cfg.guard_etus;
                                st_next.tick_count = eff_etu;
                            end
                        end
                    end
                    PH_GUARD:
                    begin
                        st_next.line_out  = 1'b1;
                        st_next.bit_index = st.bit_index - BIDX_W'(1);
                        if (st.bit_index == BIDX_FIRST)
                            st_next.phase = PH_IDLE;
                        else
                            st_next.tick_count = eff_etu;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result of the tick
    always_comb
    begin
        res                 = '0;
        res.io_drive        = st_next.line_out;
        res.busy_res        = (st_next.phase != PH_IDLE);
        res.request_dropped = (st.phase != PH_IDLE) && kind;
        if (st.phase == PH_RX && expire && st.bit_index > BIDX_PAR)
        begin
            res.rx_valid     = 1'b1;
            res.parity_error = st.parity_acc;
            res.rx_byte      = st.parity_acc ? BYTE_ERR : st.shift_bits;
        end
        if (st.phase == PH_TX && expire && st.bit_index > BIDX_LAST_D
            && cfg.guard_etus == '0)
            res.tx_done = 1'b1;
        if (st.phase == PH_GUARD && expire && st.bit_index == BIDX_FIRST)
            res.tx_done = 1'b1;
    end

endmodule

FILE: sv/smart_card_character_transceiver_core.sv
// Top level of the smart-card character transceiver: input stage, tick logic, result stage.
//
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall  | kind, io_level, tx_byte
//  out     | from block| out_valid/out_stall| io_drive, rx_valid, rx_byte, parity_error,
//          |           |                    | tx_done, busy_res, request_dropped
//  cfg     | to block  | cfg_we             | cfg_index, cfg_wdata
//
// One item per clock unless out_stall holds a full result register. Each result goes
// through the input register, then the result register. Link state advances once per item.
// Reset: line released, state idle, ETU 372 ticks, guard 2 ETUs, both stages empty.
// out_stall holds the result register and, once the input register is full, in_stall.
module smart_card_character_transceiver_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic                           io_level,
    input  logic [sctc_pkg::BYTE_W-1:0]    tx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           io_drive,
    output logic                           rx_valid,
    output logic [sctc_pkg::BYTE_W-1:0]    rx_byte,
    output logic                           parity_error,
    output logic                           tx_done,
    output logic                           busy_res,
    output logic                           request_dropped,
    input  logic                           cfg_we,
    input  logic [sctc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sctc_pkg::CFG_W-1:0]     cfg_wdata
);
    import sctc_pkg::*;

    cfg_t        cfg;
    link_state_t st_reg;
    link_state_t st_next;
    result_t     res_comb;
    result_t     res_reg;

    logic              in_v_reg;
    logic              in_v_next;
    logic              kind_reg;
    logic              io_level_reg;
    logic [BYTE_W-1:0] tx_byte_reg;
    logic              out_v_reg;
    logic              out_v_next;
    logic              adv;
    logic              in_take;
    logic              step;

    sctc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sctc_step u_step (
        .cfg      (cfg),
        .st       (st_reg),
        .kind     (kind_reg),
        .io_level (io_level_reg),
        .tx_byte  (tx_byte_reg),
        .st_next  (st_next),
        .res      (res_comb)
    );

    assign adv      = !out_v_reg || !out_stall;
    assign in_stall = in_v_reg && !adv;
    assign in_take  = in_valid && !in_stall;
    assign step     = in_v_reg && adv;

    assign in_v_next  = in_take ? 1'b1 : (adv ? 1'b0 : in_v_reg);
    assign out_v_next = adv ? in_v_reg : out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            st_reg    <= '{phase: PH_IDLE, tick_count: '0, bit_index: '0,
                           shift_bits: '0, parity_acc: 1'b0, line_out: 1'b1};
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
            if (step)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg     <= kind;
            io_level_reg <= io_level;
            tx_byte_reg  <= tx_byte;
        end
        if (step)
            res_reg <= res_comb;
    end

    assign out_valid       = out_v_reg;
    assign io_drive        = res_reg.io_drive;
    assign rx_valid        = res_reg.rx_valid;
    assign rx_byte         = res_reg.rx_byte;
    assign parity_error    = res_reg.parity_error;
    assign tx_done         = res_reg.tx_done;
    assign busy_res        = res_reg.busy_res;
    assign request_dropped = res_reg.request_dropped;

    // line is only driven low while a transmission is running
    a_low_only_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.line_out == 1'b0) |-> (st_reg.phase == PH_TX))
        else $error("line driven low outside transmit");

    // a character cannot complete on both sides in one tick
    a_rx_tx_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> !(res_reg.rx_valid && res_reg.tx_done))
        else $error("rx and tx completed together");

    // parity failure reports the error byte
    a_perr_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && res_reg.parity_error) |-> (res_reg.rx_valid && res_reg.rx_byte == BYTE_ERR))
        else $error("parity error without error byte");

    // the link state only moves when an item is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(st_reg))
        else $error("link state changed without an item");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the smart-card character transceiver core.
module tb;
    import sctc_pkg::*;

    localparam int STALL_LIMIT = 1000;

    // Tracks the link state tick by tick and holds the results still owed by the block.
    class char_link_model;
        logic [ETU_W-1:0]   etu_ticks;
        logic [GUARD_W-1:0] guard_etus;
        phase_t             phase;
        logic [ETU_W-1:0]   tick_left;
        logic [BIDX_W-1:0]  step;
        logic [BYTE_W-1:0]  shreg;
        logic               par;
        logic               line;
        result_t            pending_results[$];
        int                 errors;
        int                 n_seen;

        function new();
            etu_ticks  = ETU_RESET;
            guard_etus = GUARD_RESET;
            phase      = PH_IDLE;
            tick_left  = '0;
            step       = '0;
            shreg      = '0;
            par        = 1'b0;
            line       = 1'b1;
            errors     = 0;
            n_seen     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_ETU)
                etu_ticks = val;
            else if (idx == REG_GUARD)
                guard_etus = val[GUARD_W-1:0];
        endfunction

        function logic [ETU_W-1:0] eff_etu();
            return (etu_ticks < ETU_MIN) ? ETU_MIN : etu_ticks;
        endfunction

        function bit idle();
            return phase == PH_IDLE;
        endfunction

        function void take_tick(bit req, bit lvl, logic [BYTE_W-1:0] txb);
            result_t          r;
            logic [ETU_W-1:0] e;
            r = '0;
            e = eff_etu();
            if (phase == PH_IDLE)
            begin
                // a request beats a low line in the same tick
                if (req)
                begin
                    phase     = PH_TX;
                    line      = 1'b0;
                    shreg     = txb;
                    par       = 1'b0;
                    step      = '0;
                    tick_left = e;
                end
                else if (!lvl)
                begin
                    phase     = PH_RX;
                    shreg     = '0;
                    par       = 1'b0;
                    step      = '0;
                    tick_left = e;
                end
            end
            else
            begin
                r.request_dropped = req;
                tick_left = tick_left - ETU_W'(1);
                if (tick_left == '0)
                begin
                    unique case (phase)
                        PH_RX:
                        begin
                            if (step == '0)
                            begin
                                tick_left = e >> 1;
                                step      = BIDX_FIRST;
                            end
                            else if (step <= BIDX_LAST_D)
                            begin
                                shreg     = {lvl, shreg[BYTE_W-1:1]};
                                par       = par ^ lvl;
                                tick_left = e;
                                step      = step + BIDX_W'(1);
                            end
                            else if (step == BIDX_PAR)
                            begin
                                par       = par ^ lvl;
                                tick_left = e;
                                step      = BIDX_PAR + BIDX_W'(1);
                            end
                            else
                            begin
                                r.rx_valid     = 1'b1;
                                r.parity_error = par;
                                r.rx_byte      = par ? BYTE_ERR : shreg;
                                phase          = PH_IDLE;
                                step           = '0;
                            end
                        end
                        PH_TX:
                        begin
                            if (step < BIDX_LAST_D)
                            begin
                                line      = shreg[0];
                                par       = par ^ line;
                                shreg     = shreg >> 1;
                                tick_left = e;
                                step      = step + BIDX_W'(1);
                            end
                            else if (step == BIDX_LAST_D)
                            begin
                                line      = par;
                                tick_left = e;
                                step      = BIDX_PAR;
                            end
                            else
                            begin
                                line = 1'b1;
                                if (guard_etus == '0)
                                begin
                                    r.tx_done = 1'b1;
                                    phase     = PH_IDLE;
                                    step      = '0;
                                end
                                else
                                begin
                                    phase     = PH_GUARD;
                                    step      = guard_etus;
                                    tick_left = e;
                                end
                            end
                        end
                        default:
                        begin
                            line = 1'b1;
                            step = step - BIDX_W'(1);
                            if (step == '0)
                            begin
                                r.tx_done = 1'b1;
                                phase     = PH_IDLE;
                            end
                            else
                            begin
                                tick_left = e;
                            end
                        end
                    endcase
                end
            end
            r.io_drive = line;
            r.busy_res = (phase != PH_IDLE);
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            $display("tb: mismatch %s", msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            string   bad;
            n_seen++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", n_seen));
                return;
            end
            want = pending_results.pop_front();
            bad  = "";
            if (got.io_drive !== want.io_drive)               bad = {bad, " io_drive"};
            if (got.rx_valid !== want.rx_valid)               bad = {bad, " rx_valid"};
            if (got.rx_byte !== want.rx_byte)                 bad = {bad, " rx_byte"};
            if (got.parity_error !== want.parity_error)       bad = {bad, " parity_error"};
            if (got.tx_done !== want.tx_done)                 bad = {bad, " tx_done"};
            if (got.busy_res !== want.busy_res)               bad = {bad, " busy_res"};
            if (got.request_dropped !== want.request_dropped) bad = {bad, " request_dropped"};
            if (bad != "")
                report($sformatf("result %0d:%s got %h want %h", n_seen, bad, got, want));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 kind;
    logic                 io_level;
    logic [BYTE_W-1:0]    tx_byte;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 io_drive;
    logic                 rx_valid;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 parity_error;
    logic                 tx_done;
    logic                 busy_res;
    logic                 request_dropped;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    char_link_model link;
    bit             gaps_on = 1'b0;
    int             stall_left = 0;
    int             quiet_cycles = 0;
    int             ticks_sent = 0;
    result_t        seen;

    smart_card_character_transceiver_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .io_level        (io_level),
        .tx_byte         (tx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .io_drive        (io_drive),
        .rx_valid        (rx_valid),
        .rx_byte         (rx_byte),
        .parity_error    (parity_error),
        .tx_done         (tx_done),
        .busy_res        (busy_res),
        .request_dropped (request_dropped),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver side: random stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.io_drive        = io_drive;
            seen.rx_valid        = rx_valid;
            seen.rx_byte         = rx_byte;
            seen.parity_error    = parity_error;
            seen.tx_done         = tx_done;
            seen.busy_res        = busy_res;
            seen.request_dropped = request_dropped;
            link.check_result(seen);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Called right after a falling edge; returns right after a falling edge.
    task automatic send_tick(input bit req, input bit lvl, input logic [BYTE_W-1:0] txb);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= req;
        io_level <= lvl;
        tx_byte  <= txb;
        do
            @(posedge clk);
        while (in_stall);
        link.take_tick(req, lvl, txb);
        ticks_sent++;
        @(negedge clk);
    endtask

    // occasional request while busy, to be dropped
    function automatic bit stray_req();
        return $urandom_range(0, 24) == 0;
    endfunction

    task automatic run_until_idle(input bit noisy);
        while (!link.idle())
            send_tick(stray_req(), noisy ? 1'($urandom_range(0, 1)) : 1'b1, 8'($urandom));
    endtask

    // Card-side character: start bit, 8 data bits LSB first, parity, each one ETU.
    task automatic send_rx_char(input logic [BYTE_W-1:0] b, input bit bad_par);
        logic [ETU_W-1:0] e;
        bit               lv;
        int               i;
        int               t;
        e = link.eff_etu();
        for (i = 0; i < 10; i++)
        begin
            if (i == 0)
                lv = 1'b0;
            else if (i <= 8)
                lv = b[i-1];
            else
                lv = (^b) ^ bad_par;
            for (t = 0; t < e; t++)
                send_tick((i != 0 || t != 0) ? stray_req() : 1'b0, lv, 8'($urandom));
        end
        run_until_idle(1'b0);
    endtask

    task automatic send_tx_char(input logic [BYTE_W-1:0] b);
        send_tick(1'b1, 1'($urandom_range(0, 1)), b);
        run_until_idle(1'b1);
    endtask

    // sender pause: wait until every expected result is back
    task automatic wait_results();
        in_valid <= 1'b0;
        while (link.pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic load_regs(input logic [CFG_W-1:0] etu, input logic [GUARD_W-1:0] guard);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ETU;
        cfg_wdata <= etu;
        @(negedge clk);
        cfg_index <= REG_GUARD;
        cfg_wdata <= CFG_W'(guard);
        @(negedge clk);
        cfg_we    <= 1'b0;
        link.write_reg(REG_ETU, etu);
        link.write_reg(REG_GUARD, CFG_W'(guard));
    endtask

    task automatic random_traffic(input int n_ticks);
        int first;
        int pick;
        first = ticks_sent;
        while (ticks_sent - first < n_ticks)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 3)
            begin
                send_rx_char(8'($urandom), $urandom_range(0, 4) == 0);
            end
            else if (pick <= 6)
            begin
                send_tx_char(8'($urandom));
            end
            else if (pick == 7)
            begin
                // glitch or garbage character
                send_tick(1'b0, 1'b0, 8'($urandom));
                run_until_idle(1'b1);
            end
            else if (pick == 8)
            begin
                repeat ($urandom_range(1, 5)) send_tick(1'b0, 1'b1, 8'($urandom));
            end
            else
            begin
                send_tick(1'b1, 1'b0, 8'($urandom));
                run_until_idle(1'b1);
            end
        end
    endtask

    initial
    begin
        int                 p;
        logic [CFG_W-1:0]   etu;
        logic [GUARD_W-1:0] guard;
        link      = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = 1'b0;
        io_level  = 1'b1;
        tx_byte   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_ETU;
        cfg_wdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: short ETU with the reset guard time, request together with a low line
        gaps_on = 1'b1;
        cfg_we    <= 1'b1;
        cfg_index <= REG_ETU;
        cfg_wdata <= CFG_W'(2);
        @(negedge clk);
        cfg_we    <= 1'b0;
        link.write_reg(REG_ETU, CFG_W'(2));
        send_tick(1'b1, 1'b0, 8'hA5);
        run_until_idle(1'b0);

        // ETU below two, zero guard
        wait_results();
        load_regs(CFG_W'(1), GUARD_W'(0));
        send_tx_char(8'h00);
        send_tx_char(8'hFF);

        // odd ETU: half interval rounds down; longest guard
        wait_results();
        load_regs(CFG_W'(3), GUARD_W'(15));
        send_rx_char(8'h00, 1'b0);
        send_rx_char(8'hFF, 1'b0);
        send_rx_char(8'h5A, 1'b1);
        send_rx_char(8'h80, 1'b0);
        send_tx_char(8'h01);

        // registers change while a character is under way
        send_tick(1'b0, 1'b0, 8'h00);
        repeat (5) send_tick(1'b0, 1'b1, 8'h00);
        wait_results();
        load_regs(CFG_W'(4), GUARD_W'(1));
        run_until_idle(1'b1);

        for (p = 0; p < 9; p++)
        begin
            wait_results();
            gaps_on = (p < 8) && ($urandom_range(0, 3) != 0);
            unique case (p)
                0: begin etu = CFG_W'(2); guard = GUARD_W'(0);  end
                1: begin etu = CFG_W'(0); guard = GUARD_W'(1);  end
                2: begin etu = CFG_W'(1); guard = GUARD_W'(15); end
                3: begin etu = CFG_W'(3); guard = GUARD_W'(2);  end
                4: begin etu = CFG_W'(4); guard = GUARD_W'(0);  end
                5: begin etu = CFG_W'(2); guard = GUARD_W'(5);  end
                6: begin etu = CFG_W'(6); guard = GUARD_W'(15); end
                7: begin etu = CFG_W'(3); guard = GUARD_W'($urandom); end
                default:
                begin
                    etu   = CFG_W'($urandom_range(2, 4));
                    guard = GUARD_W'($urandom);
                end
            endcase
            load_regs(etu, guard);
            random_traffic(18);
        end

        wait_results();
        if (link.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
